// ----- hw/rtl/trace_pattern_edge_search_unit_assert.svh -----
// Assertion macros used by the checker file of the trace search unit.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef TRACE_PATTERN_EDGE_SEARCH_UNIT_ASSERT_SVH
`define TRACE_PATTERN_EDGE_SEARCH_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPES_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TPES_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/tpes_pkg.sv -----
// Package of the trace pattern search unit: widths, register codes, reset values
// and the types passed between its modules. No dependencies.
package tpes_pkg;

  // Field widths.
  localparam int WORD_W      = 16;
  localparam int SEL_W       = 3;
  localparam int ROW_LIMIT_W = 17;
  localparam int PERIOD_W    = 32;
  localparam int ELAPSED_W   = 49;
  localparam int TIME_W      = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // Default search limits.
  localparam int MAX_REPORTS_DEF = 11;
  localparam int MAX_ROWS_DEF    = 65536;

  // Picoseconds per nanosecond, split as an odd factor and a shift.
  localparam int PS_PER_NS = 1000;
  localparam int PRE_SHIFT = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLOCK_TARGET = 3'd0,
    REG_CLOCK_MASK   = 3'd1,
    REG_POD_TARGET   = 3'd2,
    REG_POD_MASK     = 3'd3,
    REG_POD_SELECT   = 3'd4,
    REG_EDGE_MODE    = 3'd5,
    REG_ROW_LIMIT    = 3'd6,
    REG_SAMPLE_PER   = 3'd7
  } cfg_reg_e;

  // Pod select codes.
  localparam logic [SEL_W-1:0] POD_SEL_1 = 3'd1;
  localparam logic [SEL_W-1:0] POD_SEL_2 = 3'd2;
  localparam logic [SEL_W-1:0] POD_SEL_3 = 3'd3;
  localparam logic [SEL_W-1:0] POD_SEL_4 = 3'd4;

  // Register reset values.
  localparam logic [SEL_W-1:0]       POD_SELECT_RST = POD_SEL_1;
  localparam logic                   EDGE_MODE_RST  = 1'b1;
  localparam logic [ROW_LIMIT_W-1:0] ROW_LIMIT_RST  = 17'd65536;
  localparam logic [PERIOD_W-1:0]    PERIOD_RST     = 32'd8000;

  typedef struct packed {
    logic [WORD_W-1:0]      clock_target;
    logic [WORD_W-1:0]      clock_mask;
    logic [WORD_W-1:0]      pod_target;
    logic [WORD_W-1:0]      pod_mask;
    logic [SEL_W-1:0]       pod_select;
    logic                   edge_mode;
    logic [ROW_LIMIT_W-1:0] row_limit;
    logic [PERIOD_W-1:0]    sample_period_ps;
  } cfg_t;

  // Report fields that ride along with the time conversion.
  typedef struct packed {
    logic [WORD_W-1:0] row_number;
    logic [WORD_W-1:0] clock_seen;
    logic [WORD_W-1:0] pod_seen;
    logic              search_done;
  } rep_t;

endpackage

// ----- hw/rtl/tpes_cfg_regs.sv -----
// Configuration register file of the trace pattern search unit.
// Depends on tpes_pkg for the register codes, reset values and cfg_t.
module tpes_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_wr_en_i,
  input  logic [tpes_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tpes_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output tpes_pkg::cfg_t                  cfg_o
);
  import tpes_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the register index and take the low bits of the write data.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr_en_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_CLOCK_TARGET: cfg_d.clock_target     = cfg_data_i[WORD_W-1:0];
        REG_CLOCK_MASK:   cfg_d.clock_mask       = cfg_data_i[WORD_W-1:0];
        REG_POD_TARGET:   cfg_d.pod_target       = cfg_data_i[WORD_W-1:0];
        REG_POD_MASK:     cfg_d.pod_mask         = cfg_data_i[WORD_W-1:0];
        REG_POD_SELECT:   cfg_d.pod_select       = cfg_data_i[SEL_W-1:0];
        REG_EDGE_MODE:    cfg_d.edge_mode        = cfg_data_i[0];
        REG_ROW_LIMIT:    cfg_d.row_limit        = cfg_data_i[ROW_LIMIT_W-1:0];
        REG_SAMPLE_PER:   cfg_d.sample_period_ps = cfg_data_i[PERIOD_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clock_target     <= '0;
      cfg_q.clock_mask       <= '0;
      cfg_q.pod_target       <= '0;
      cfg_q.pod_mask         <= '0;
      cfg_q.pod_select       <= POD_SELECT_RST;
      cfg_q.edge_mode        <= EDGE_MODE_RST;
      cfg_q.row_limit        <= ROW_LIMIT_RST;
      cfg_q.sample_period_ps <= PERIOD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/tpes_search.sv -----
// Search stage: masked compares, match flags, row and report counting and the
// picosecond accumulator. Depends on tpes_pkg for cfg_t, rep_t and widths.
module tpes_search #(
  parameter int MAX_REPORTS = tpes_pkg::MAX_REPORTS_DEF,
  parameter int MAX_ROWS    = tpes_pkg::MAX_ROWS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tpes_pkg::cfg_t                 cfg_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           start_of_trace_i,
  input  logic [tpes_pkg::WORD_W-1:0]    clock_word_i,
  input  logic [tpes_pkg::WORD_W-1:0]    pod4_word_i,
  input  logic [tpes_pkg::WORD_W-1:0]    pod3_word_i,
  input  logic [tpes_pkg::WORD_W-1:0]    pod2_word_i,
  input  logic [tpes_pkg::WORD_W-1:0]    pod1_word_i,
  output logic                           rep_valid_o,
  input  logic                           rep_ready_i,
  output tpes_pkg::rep_t                 rep_o,
  output logic [tpes_pkg::ELAPSED_W-1:0] elapsed_o
);
  import tpes_pkg::*;

  localparam int ROW_W = $clog2(MAX_ROWS + 1);
  localparam int CMP_W = (ROW_W > ROW_LIMIT_W) ? ROW_W : ROW_LIMIT_W;
  localparam int CNT_W = $clog2(MAX_REPORTS + 1);
  localparam logic [ELAPSED_W:0] ELAPSED_MAX = {1'b0, {ELAPSED_W{1'b1}}};

  // Search state.
  logic                 last_clk_q, last_clk_d;
  logic                 last_pod_q, last_pod_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [ROW_W-1:0]     rows_q, rows_d;
  logic [ELAPSED_W-1:0] elapsed_q, elapsed_d;
  logic                 stopped_q, stopped_d;

  // Report register.
  logic                 rep_valid_q, rep_valid_d;
  rep_t                 rep_q;
  logic [ELAPSED_W-1:0] rep_elapsed_q;

  // Working signals.
  logic                 accept, active;
  logic                 eff_last_clk, eff_last_pod, eff_stopped;
  logic [CNT_W-1:0]     eff_cnt, cnt_next;
  logic [ROW_W-1:0]     eff_rows, rows_next;
  logic [ELAPSED_W-1:0] eff_elapsed, elapsed_next;
  logic [ELAPSED_W:0]   elapsed_sum;
  logic                 sel_ok;
  logic [WORD_W-1:0]    pod_word;
  logic                 clk_en, pod_en, clk_hit, pod_hit;
  logic                 report, row_stop, cnt_stop;
  logic [CMP_W-1:0]     row_ext;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = rep_valid_q && !rep_ready_i;

  // Start of trace restores the cleared search state before the row is handled.
  always_comb begin
    if (start_of_trace_i) begin
      eff_last_clk = 1'b1;
      eff_last_pod = 1'b1;
      eff_cnt      = '0;
      eff_rows     = '0;
      eff_elapsed  = '0;
      eff_stopped  = 1'b0;
    end else begin
      eff_last_clk = last_clk_q;
      eff_last_pod = last_pod_q;
      eff_cnt      = cnt_q;
      eff_rows     = rows_q;
      eff_elapsed  = elapsed_q;
      eff_stopped  = stopped_q;
    end
  end

  assign active = !eff_stopped;

  // Pod selection; a code outside one to four disables both channels.
  always_comb begin
    sel_ok   = 1'b1;
    pod_word = '0;
    unique case (cfg_i.pod_select)
      POD_SEL_1: pod_word = pod1_word_i;
      POD_SEL_2: pod_word = pod2_word_i;
      POD_SEL_3: pod_word = pod3_word_i;
      POD_SEL_4: pod_word = pod4_word_i;
      default:   sel_ok   = 1'b0;
    endcase
  end

  // Masked compares; a zero mask disables its channel.
  assign clk_en  = sel_ok && (cfg_i.clock_mask != '0);
  assign pod_en  = sel_ok && (cfg_i.pod_mask != '0);
  assign clk_hit = (clock_word_i & cfg_i.clock_mask) == cfg_i.clock_target;
  assign pod_hit = (pod_word & cfg_i.pod_mask) == cfg_i.pod_target;

  // Report decision and flag update; flags move only in edge mode on enabled channels.
  always_comb begin
    if (cfg_i.edge_mode) begin
      report = (clk_en && (clk_hit != eff_last_clk)) ||
               (pod_en && (pod_hit != eff_last_pod));
    end else begin
      report = (clk_en && clk_hit) || (pod_en && pod_hit);
    end
    last_clk_d = (cfg_i.edge_mode && clk_en) ? clk_hit : eff_last_clk;
    last_pod_d = (cfg_i.edge_mode && pod_en) ? pod_hit : eff_last_pod;
  end

  // Row count, saturating time accumulator and the two stop conditions.
  always_comb begin
    rows_next    = eff_rows + ROW_W'(1);
    row_stop     = (CMP_W'(rows_next) >= CMP_W'(cfg_i.row_limit)) ||
                   (rows_next >= ROW_W'(MAX_ROWS));
    elapsed_sum  = {1'b0, eff_elapsed} + (ELAPSED_W + 1)'(cfg_i.sample_period_ps);
    elapsed_next = (elapsed_sum > ELAPSED_MAX) ? ELAPSED_MAX[ELAPSED_W-1:0]
                                               : elapsed_sum[ELAPSED_W-1:0];
    cnt_next     = report ? (eff_cnt + CNT_W'(1)) : eff_cnt;
    cnt_stop     = report && (cnt_next >= CNT_W'(MAX_REPORTS));
    row_ext      = CMP_W'(eff_rows);
  end

  // Stopped rows leave the state alone unless they start a new trace.
  always_comb begin
    cnt_d     = cnt_q;
    rows_d    = rows_q;
    elapsed_d = elapsed_q;
    stopped_d = stopped_q;
    if (accept && active) begin
      cnt_d     = cnt_next;
      rows_d    = rows_next;
      elapsed_d = elapsed_next;
      stopped_d = row_stop || cnt_stop;
    end
  end

  // The report register frees itself as soon as the next stage takes it.
  always_comb begin
    if (accept) begin
      rep_valid_d = active && report;
    end else if (rep_ready_i) begin
      rep_valid_d = 1'b0;
    end else begin
      rep_valid_d = rep_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_clk_q  <= 1'b1;
      last_pod_q  <= 1'b1;
      cnt_q       <= '0;
      rows_q      <= '0;
      elapsed_q   <= '0;
      stopped_q   <= 1'b0;
      rep_valid_q <= 1'b0;
    end else begin
      if (accept && active) begin
        last_clk_q <= last_clk_d;
        last_pod_q <= last_pod_d;
      end
      cnt_q       <= cnt_d;
      rows_q      <= rows_d;
      elapsed_q   <= elapsed_d;
      stopped_q   <= stopped_d;
      rep_valid_q <= rep_valid_d;
    end
  end

  // Report payload, loaded only when a report is made.
  always_ff @(posedge clk_i) begin
    if (accept && active && report) begin
      rep_q.row_number  <= row_ext[WORD_W-1:0];
      rep_q.clock_seen  <= clock_word_i;
      rep_q.pod_seen    <= pod_word;
      rep_q.search_done <= row_stop || cnt_stop;
      rep_elapsed_q     <= eff_elapsed;
    end
  end

  assign rep_valid_o = rep_valid_q;
  assign rep_o       = rep_q;
  assign elapsed_o   = rep_elapsed_q;

endmodule

// ----- hw/rtl/tpes_div1000.sv -----
// Pipelined conversion of elapsed picoseconds to nanoseconds: a shift by three
// and a long division by 125, eight quotient bits per stage. Depends on tpes_pkg.
module tpes_div1000 (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tpes_pkg::ELAPSED_W-1:0] elapsed_i,
  input  tpes_pkg::rep_t                 rep_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output tpes_pkg::rep_t                 rep_o,
  output logic [tpes_pkg::TIME_W-1:0]    time_ns_o
);
  import tpes_pkg::*;

  localparam int DVD_W   = TIME_W;
  localparam int STEP    = 8;
  localparam int STAGES  = DVD_W / STEP;
  localparam int DIVISOR = PS_PER_NS >> PRE_SHIFT;
  localparam int REM_W   = $clog2(DIVISOR);

  // Eight restoring division steps on the running remainder.
  function automatic logic [REM_W+STEP-1:0] div_digit(
    input logic [REM_W-1:0] rem_in,
    input logic [STEP-1:0]  bits
  );
    logic [REM_W-1:0] r;
    logic [REM_W:0]   trial;
    logic [STEP-1:0]  q;
    r = rem_in;
    q = '0;
    for (int j = STEP - 1; j >= 0; j--) begin
      trial = {r, bits[j]};
      if (trial >= (REM_W + 1)'(DIVISOR)) begin
        r    = REM_W'(trial - (REM_W + 1)'(DIVISOR));
        q[j] = 1'b1;
      end else begin
        r = trial[REM_W-1:0];
      end
    end
    return {r, q};
  endfunction

  logic             src_v   [STAGES];
  logic [DVD_W-1:0] src_dvd [STAGES];
  logic [DVD_W-1:0] src_quo [STAGES];
  logic [REM_W-1:0] src_rem [STAGES];
  rep_t             src_rep [STAGES];

  logic             v_q   [STAGES];
  logic [DVD_W-1:0] dvd_q [STAGES];
  logic [DVD_W-1:0] quo_q [STAGES];
  logic [REM_W-1:0] rem_q [STAGES];
  rep_t             rep_q [STAGES];

  logic             rdy   [STAGES+1];

  // A stage takes new data when it is empty or its contents move on.
  assign rdy[STAGES] = !out_stall_i;
  assign in_ready_o  = rdy[0];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic [REM_W+STEP-1:0] digit;

    // Stage inputs: the search report for the first stage, the stage before otherwise.
    if (k == 0) begin : g_first
      assign src_v[k]   = in_valid_i;
      assign src_dvd[k] = DVD_W'(elapsed_i[ELAPSED_W-1:PRE_SHIFT]);
      assign src_quo[k] = '0;
      assign src_rem[k] = '0;
      assign src_rep[k] = rep_i;
    end else begin : g_next
      assign src_v[k]   = v_q[k-1];
      assign src_dvd[k] = dvd_q[k-1];
      assign src_quo[k] = quo_q[k-1];
      assign src_rem[k] = rem_q[k-1];
      assign src_rep[k] = rep_q[k-1];
    end

    assign rdy[k] = !v_q[k] || rdy[k+1];
    assign digit  = div_digit(src_rem[k], src_dvd[k][DVD_W-1 -: STEP]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= src_v[k];
      end
    end

    // Shift the next dividend byte up and the new quotient byte in.
    always_ff @(posedge clk_i) begin
      if (rdy[k] && src_v[k]) begin
        dvd_q[k] <= src_dvd[k] << STEP;
        quo_q[k] <= {src_quo[k][DVD_W-STEP-1:0], digit[STEP-1:0]};
        rem_q[k] <= digit[REM_W+STEP-1:STEP];
        rep_q[k] <= src_rep[k];
      end
    end
  end

  assign out_valid_o = v_q[STAGES-1];
  assign rep_o       = rep_q[STAGES-1];
  assign time_ns_o   = quo_q[STAGES-1];

endmodule

// ----- hw/rtl/trace_pattern_edge_search_unit.sv -----
// Top level of the logic analyzer masked pattern search unit.
// Depends on tpes_pkg, tpes_cfg_regs, tpes_search and tpes_div1000.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   start_of_trace, clock and four pod words
//   out      output     out_valid_o / out_stall_i row, clock, pod, time_ns, search_done
//   cfg      input      cfg_wr_en_i               cfg_index_i, cfg_data_i
//
// One trace row is accepted per clock cycle while in_stall_o is low; a report passes
// through the search register and then the six stages of the nanosecond divider.
// Rows that make no report leave nothing in the pipeline.
// Reset is asynchronous and active low and takes effect at once; no clearing pass.
// Out stall holds the pipeline; in stall rises only when every stage holds a report.
module trace_pattern_edge_search_unit #(
  parameter int MAX_REPORTS = tpes_pkg::MAX_REPORTS_DEF,
  parameter int MAX_ROWS    = tpes_pkg::MAX_ROWS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_wr_en_i,
  input  logic [tpes_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tpes_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            start_of_trace_i,
  input  logic [tpes_pkg::WORD_W-1:0]     clock_word_i,
  input  logic [tpes_pkg::WORD_W-1:0]     pod4_word_i,
  input  logic [tpes_pkg::WORD_W-1:0]     pod3_word_i,
  input  logic [tpes_pkg::WORD_W-1:0]     pod2_word_i,
  input  logic [tpes_pkg::WORD_W-1:0]     pod1_word_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [tpes_pkg::WORD_W-1:0]     row_number_o,
  output logic [tpes_pkg::WORD_W-1:0]     clock_seen_o,
  output logic [tpes_pkg::WORD_W-1:0]     pod_seen_o,
  output logic [tpes_pkg::TIME_W-1:0]     time_ns_o,
  output logic                            search_done_o
);
  import tpes_pkg::*;

  cfg_t                 cfg;
  logic                 rep_valid, rep_ready;
  rep_t                 rep_srch, rep_out;
  logic [ELAPSED_W-1:0] rep_elapsed;

  // Configuration registers.
  tpes_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wr_en_i (cfg_wr_en_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Match search and state update on each accepted row.
  tpes_search #(
    .MAX_REPORTS (MAX_REPORTS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_search (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .start_of_trace_i (start_of_trace_i),
    .clock_word_i     (clock_word_i),
    .pod4_word_i      (pod4_word_i),
    .pod3_word_i      (pod3_word_i),
    .pod2_word_i      (pod2_word_i),
    .pod1_word_i      (pod1_word_i),
    .rep_valid_o      (rep_valid),
    .rep_ready_i      (rep_ready),
    .rep_o            (rep_srch),
    .elapsed_o        (rep_elapsed)
  );

  // Picosecond to nanosecond conversion of each report.
  tpes_div1000 u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rep_valid),
    .in_ready_o  (rep_ready),
    .elapsed_i   (rep_elapsed),
    .rep_i       (rep_srch),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .rep_o       (rep_out),
    .time_ns_o   (time_ns_o)
  );

  assign row_number_o  = rep_out.row_number;
  assign clock_seen_o  = rep_out.clock_seen;
  assign pod_seen_o    = rep_out.pod_seen;
  assign search_done_o = rep_out.search_done;

endmodule

// ----- hw/rtl/tpes_checker.sv -----
// Port checker of the trace search unit and its bind to the top level.
// Depends on tpes_pkg and trace_pattern_edge_search_unit_assert.svh.
`include "trace_pattern_edge_search_unit_assert.svh"

module tpes_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_stall_i,
  input logic                         out_valid_i,
  input logic                         out_stall_i,
  input logic [tpes_pkg::WORD_W-1:0]  row_number_i,
  input logic [tpes_pkg::TIME_W-1:0]  time_ns_i,
  input logic                         search_done_i
);
  import tpes_pkg::*;

  // A held transaction stays valid.
  `TPES_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i)

  // A held transaction keeps its row and time.
  `TPES_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_i && out_stall_i, $stable(row_number_i) && $stable(time_ns_i) && $stable(search_done_i))

  // Input backpressure only appears when the output is full and held.
  `TPES_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_i, out_valid_i && out_stall_i)

  // The saturated picosecond count divided by 1000 stays below two to the fortieth.
  `TPES_ASSERT_IMP(a_time_range, clk_i, rst_ni, out_valid_i, time_ns_i[TIME_W-1:40] == '0)

endmodule

bind trace_pattern_edge_search_unit tpes_checker u_tpes_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_i    (in_stall_o),
  .out_valid_i   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .row_number_i  (row_number_o),
  .time_ns_i     (time_ns_o),
  .search_done_i (search_done_o)
);

// ----- dv/tb_top.sv -----
// Testbench for trace_pattern_edge_search_unit: streams trace rows through the unit,
// predicts each search report in step with the rows and checks every report field.
// Depends on tpes_pkg and the RTL of the unit.
`timescale 1ns / 100ps

module tb_top;
  import tpes_pkg::*;

  localparam int TIMEOUT_NS   = 3_000_000;
  localparam int SETTLE_CYC   = 12;
  localparam int IDLE_PCT     = 37;
  localparam int HOLD_CYC     = 80;
  localparam int RANDOM_ROWS  = 120;
  localparam int RANDOM_SETS  = 9;
  localparam int PRESSURE_ROWS = 160;
  localparam logic [ELAPSED_W-1:0] ELAPSED_SAT = {ELAPSED_W{1'b1}};

  // One trace row as it goes onto the input channel.
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] clock_word;
    logic [WORD_W-1:0] pod4;
    logic [WORD_W-1:0] pod3;
    logic [WORD_W-1:0] pod2;
    logic [WORD_W-1:0] pod1;
  } trace_row_t;

  // One search report as it leaves the unit.
  typedef struct packed {
    logic [WORD_W-1:0] row_number;
    logic [WORD_W-1:0] clock_seen;
    logic [WORD_W-1:0] pod_seen;
    logic [TIME_W-1:0] time_ns;
    logic              search_done;
  } report_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_wr_en;
  cfg_reg_e cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  trace_row_t on_bus;
  logic out_valid;
  logic out_stall;
  logic [WORD_W-1:0] row_number;
  logic [WORD_W-1:0] clock_seen;
  logic [WORD_W-1:0] pod_seen;
  logic [TIME_W-1:0] time_ns;
  logic search_done;

  // Stimulus and scoreboard storage.
  trace_row_t trace_rows[$];
  report_t    awaited_reports[$];
  int         mismatch_count = 0;
  int         rows_handled = 0;
  logic       row_taken = 1'b0;
  logic       send_calm = 1'b0;
  logic       recv_calm = 1'b0;
  logic       hold_go = 1'b0;
  logic       hold_used = 1'b0;
  int         hold_left = 0;

  // Search model: register copy and search state.
  cfg_t                   search_cfg;
  logic                   last_clk_hit;
  logic                   last_pod_hit;
  logic [3:0]             report_cnt;
  logic [ROW_LIMIT_W-1:0] rows_seen;
  logic [ELAPSED_W-1:0]   elapsed_ps;
  logic                   search_stopped;

  trace_pattern_edge_search_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_wr_en_i      (cfg_wr_en),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .start_of_trace_i (on_bus.start),
    .clock_word_i     (on_bus.clock_word),
    .pod4_word_i      (on_bus.pod4),
    .pod3_word_i      (on_bus.pod3),
    .pod2_word_i      (on_bus.pod2),
    .pod1_word_i      (on_bus.pod1),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .row_number_o     (row_number),
    .clock_seen_o     (clock_seen),
    .pod_seen_o       (pod_seen),
    .time_ns_o        (time_ns),
    .search_done_o    (search_done)
  );

  // Clock generation.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Advances the search model by one accepted row and queues the report it causes.
  function automatic void search_row(input trace_row_t r);
    logic [WORD_W-1:0]      pod_w;
    logic                   sel_ok, clk_en, pod_en, clk_hit, pod_hit, hit;
    logic [ELAPSED_W:0]     sum;
    logic [63:0]            ns_full;
    report_t                rep;
    if (r.start) begin
      last_clk_hit   = 1'b1;
      last_pod_hit   = 1'b1;
      report_cnt     = '0;
      rows_seen      = '0;
      elapsed_ps     = '0;
      search_stopped = 1'b0;
    end
    if (search_stopped) return;
    rows_handled++;

    // Pod selection; a code outside one to four disables both channels.
    sel_ok = 1'b1;
    case (search_cfg.pod_select)
      POD_SEL_1: pod_w = r.pod1;
      POD_SEL_2: pod_w = r.pod2;
      POD_SEL_3: pod_w = r.pod3;
      POD_SEL_4: pod_w = r.pod4;
      default: begin
        pod_w  = '0;
        sel_ok = 1'b0;
      end
    endcase
    clk_en  = sel_ok && search_cfg.clock_mask != '0;
    pod_en  = sel_ok && search_cfg.pod_mask != '0;
    clk_hit = (r.clock_word & search_cfg.clock_mask) == search_cfg.clock_target;
    pod_hit = (pod_w & search_cfg.pod_mask) == search_cfg.pod_target;

    // Edge mode reports flag changes of enabled channels, level mode reports matches.
    hit = 1'b0;
    if (search_cfg.edge_mode) begin
      if (clk_en && clk_hit != last_clk_hit) begin
        hit = 1'b1;
        last_clk_hit = clk_hit;
      end
      if (pod_en && pod_hit != last_pod_hit) begin
        hit = 1'b1;
        last_pod_hit = pod_hit;
      end
    end else begin
      hit = (clk_en && clk_hit) || (pod_en && pod_hit);
    end

    rep.row_number = rows_seen[WORD_W-1:0];
    rep.clock_seen = r.clock_word;
    rep.pod_seen   = pod_w;
    ns_full        = {{(64-ELAPSED_W){1'b0}}, elapsed_ps} / 64'(PS_PER_NS);
    rep.time_ns    = ns_full[TIME_W-1:0];

    // Row count and time advance on every handled row; time saturates.
    rows_seen++;
    sum = {1'b0, elapsed_ps} + (ELAPSED_W+1)'(search_cfg.sample_period_ps);
    elapsed_ps = (sum > {1'b0, ELAPSED_SAT}) ? ELAPSED_SAT : sum[ELAPSED_W-1:0];
    if (rows_seen >= search_cfg.row_limit || int'(rows_seen) >= MAX_ROWS_DEF)
      search_stopped = 1'b1;
    if (!hit) return;

    report_cnt++;
    if (int'(report_cnt) >= MAX_REPORTS_DEF) search_stopped = 1'b1;
    rep.search_done = search_stopped;
    awaited_reports.push_back(rep);
  endfunction

  // A word that meets the masked target about half of the time.
  function automatic logic [WORD_W-1:0] near_word(input logic [WORD_W-1:0] target,
                                                  input logic [WORD_W-1:0] mask);
    logic [WORD_W-1:0] rnd;
    rnd = WORD_W'($urandom);
    return $urandom_range(1) ? ((target & mask) | (rnd & ~mask)) : rnd;
  endfunction

  // A random row shaped by the current search settings.
  function automatic trace_row_t make_row();
    trace_row_t r;
    r.start = (search_cfg.row_limit < 24) ? ($urandom_range(3) == 0)
                                          : ($urandom_range(13) == 0);
    r.clock_word = near_word(search_cfg.clock_target, search_cfg.clock_mask);
    r.pod4 = near_word(search_cfg.pod_target, search_cfg.pod_mask);
    r.pod3 = near_word(search_cfg.pod_target, search_cfg.pod_mask);
    r.pod2 = near_word(search_cfg.pod_target, search_cfg.pod_mask);
    r.pod1 = near_word(search_cfg.pod_target, search_cfg.pod_mask);
    return r;
  endfunction

  // Writes one register and mirrors it into the model copy.
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_CLOCK_TARGET: search_cfg.clock_target     = data[WORD_W-1:0];
      REG_CLOCK_MASK:   search_cfg.clock_mask       = data[WORD_W-1:0];
      REG_POD_TARGET:   search_cfg.pod_target       = data[WORD_W-1:0];
      REG_POD_MASK:     search_cfg.pod_mask         = data[WORD_W-1:0];
      REG_POD_SELECT:   search_cfg.pod_select       = data[SEL_W-1:0];
      REG_EDGE_MODE:    search_cfg.edge_mode        = data[0];
      REG_ROW_LIMIT:    search_cfg.row_limit        = data[ROW_LIMIT_W-1:0];
      REG_SAMPLE_PER:   search_cfg.sample_period_ps = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_wr_en <= 1'b0;
  endtask

  // Waits until every row is taken and every report has arrived, then lets
  // the pipeline settle.
  task automatic wait_quiet();
    do @(posedge clk_i);
    while (trace_rows.size() != 0 || in_valid || awaited_reports.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic queue_row(input logic st, input logic [WORD_W-1:0] ck,
                           input logic [WORD_W-1:0] p4, input logic [WORD_W-1:0] p3,
                           input logic [WORD_W-1:0] p2, input logic [WORD_W-1:0] p1);
    trace_rows.push_back('{st, ck, p4, p3, p2, p1});
  endtask

  // Loads a random setting, with the extremes of the masks, row limit and sample period weighted up.
  task automatic random_search_cfg();
    logic [WORD_W-1:0]     c_mask, p_mask;
    logic [CFG_DATA_W-1:0] limit, period;
    int                    pick;
    pick = $urandom_range(9);
    c_mask = (pick == 0) ? 16'h0000 : (pick < 3) ? 16'hFFFF : WORD_W'($urandom);
    pick = $urandom_range(9);
    p_mask = (pick == 0) ? 16'h0000 : (pick < 3) ? 16'hFFFF : WORD_W'($urandom);
    pick = $urandom_range(19);
    limit = (pick < 3) ? $urandom_range(20) : (pick == 3) ? 32'd0 :
            (pick == 4) ? 32'd65536 : (pick == 5) ? ($urandom | 32'h1FFFF) :
            $urandom_range(65536, 200);
    pick = $urandom_range(9);
    period = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF :
             (pick == 2) ? 32'd8000 : $urandom;
    write_reg(REG_CLOCK_MASK, {16'($urandom), c_mask});
    write_reg(REG_CLOCK_TARGET, ($urandom_range(7) == 0) ? $urandom
                                : {16'($urandom), 16'($urandom) & c_mask});
    write_reg(REG_POD_MASK, {16'($urandom), p_mask});
    write_reg(REG_POD_TARGET, ($urandom_range(7) == 0) ? $urandom
                              : {16'($urandom), 16'($urandom) & p_mask});
    write_reg(REG_POD_SELECT, ($urandom_range(9) == 0) ? $urandom
                              : {29'($urandom), 3'($urandom_range(4, 1))});
    write_reg(REG_EDGE_MODE, $urandom);
    write_reg(REG_ROW_LIMIT, limit);
    write_reg(REG_SAMPLE_PER, period);
  endtask

  // Row driver: offers the next queued row, idling at random between transactions.
  always @(negedge clk_i) begin
    if (!in_valid || row_taken) begin
      row_taken = 1'b0;
      if (trace_rows.size() != 0 && (send_calm || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        on_bus   <= trace_rows.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Report receiver: random stalls, plus one long hold-off when requested.
  always @(negedge clk_i) begin
    if (hold_go && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYC;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !recv_calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Checks each report transaction and feeds each row transaction to the model.
  always @(posedge clk_i) begin : scoreboard
    report_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (awaited_reports.size() == 0) begin
          $error("report for row %0d arrived with none awaited", row_number);
          mismatch_count++;
        end else begin
          want = awaited_reports.pop_front();
          if (want.row_number !== row_number) begin
            $error("row_number: expected %0d, actual %0d", want.row_number, row_number);
            mismatch_count++;
          end
          if (want.clock_seen !== clock_seen) begin
            $error("clock_seen: expected %h, actual %h", want.clock_seen, clock_seen);
            mismatch_count++;
          end
          if (want.pod_seen !== pod_seen) begin
            $error("pod_seen: expected %h, actual %h", want.pod_seen, pod_seen);
            mismatch_count++;
          end
          if (want.time_ns !== time_ns) begin
            $error("time_ns: expected %0d, actual %0d", want.time_ns, time_ns);
            mismatch_count++;
          end
          if (want.search_done !== search_done) begin
            $error("search_done: expected %b, actual %b", want.search_done, search_done);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        row_taken = 1'b1;
        search_row(on_bus);
      end
    end
  end

  // Overall time limit.
  initial begin
    #(TIMEOUT_NS);
    $display("FAILED: results differ");
    $finish;
  end

  // Stimulus sequence.
  initial begin
    int goal;
    rst_ni    = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_CLOCK_TARGET;
    cfg_data  = '0;
    in_valid  = 1'b0;
    on_bus    = '0;
    out_stall = 1'b0;
    search_cfg = '{clock_target: '0, clock_mask: '0, pod_target: '0, pod_mask: '0,
                   pod_select: POD_SELECT_RST, edge_mode: EDGE_MODE_RST,
                   row_limit: ROW_LIMIT_RST, sample_period_ps: PERIOD_RST};
    last_clk_hit   = 1'b1;
    last_pod_hit   = 1'b1;
    report_cnt     = '0;
    rows_seen      = '0;
    elapsed_ps     = '0;
    search_stopped = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: both masks are zero, so rows are counted but never reported.
    queue_row(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_row(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_row(1'b0, 16'h5A5A, 16'hA5A5, 16'h3C3C, 16'hC3C3, 16'h0F0F);
    wait_quiet();

    // Edge mode on pod four with the longest sample period; target has junk above 16 bits.
    write_reg(REG_CLOCK_TARGET, 32'hFFFF_00A5);
    write_reg(REG_CLOCK_MASK, 32'h0000_00FF);
    write_reg(REG_POD_TARGET, 32'h0000_C000);
    write_reg(REG_POD_MASK, 32'h0000_F000);
    write_reg(REG_POD_SELECT, 32'd4);
    write_reg(REG_EDGE_MODE, 32'd1);
    write_reg(REG_ROW_LIMIT, 32'd65536);
    write_reg(REG_SAMPLE_PER, 32'hFFFF_FFFF);
    queue_row(1'b1, 16'h00A5, 16'hC123, 16'h0000, 16'h0000, 16'h0000);
    queue_row(1'b0, 16'h0000, 16'hC000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_row(1'b0, 16'h0000, 16'h0000, 16'hC000, 16'hC000, 16'hC000);
    queue_row(1'b0, 16'hFFA5, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    queue_row(1'b0, 16'h00A5, 16'hC000, 16'h0000, 16'h0000, 16'h0000);
    queue_row(1'b1, 16'h0000, 16'h0000, 16'hC000, 16'hC000, 16'hC000);
    wait_quiet();

    // Level mode with pod select outside one to four: the search is disabled.
    write_reg(REG_EDGE_MODE, 32'd0);
    write_reg(REG_POD_SELECT, 32'd0);
    queue_row(1'b1, 16'h00A5, 16'hC000, 16'hC000, 16'hC000, 16'hC000);
    wait_quiet();
    write_reg(REG_POD_SELECT, 32'hFFFF_FFFF);
    queue_row(1'b0, 16'h00A5, 16'hC000, 16'hC000, 16'hC000, 16'hC000);
    wait_quiet();

    // Clock target outside its mask never matches; a row limit of zero still
    // handles one row, and later rows wait for a new trace.
    write_reg(REG_POD_SELECT, 32'd1);
    write_reg(REG_CLOCK_TARGET, 32'h0000_0100);
    write_reg(REG_ROW_LIMIT, 32'd0);
    queue_row(1'b1, 16'h0100, 16'hC000, 16'hC000, 16'hC000, 16'hC000);
    queue_row(1'b0, 16'h00A5, 16'hC000, 16'hC000, 16'hC000, 16'hC000);
    queue_row(1'b1, 16'h01A5, 16'h0000, 16'h0000, 16'h0000, 16'hC0FF);
    wait_quiet();

    // Every row matches, with a new trace every twelve rows, so the report limit
    // is hit in each full trace. The receiver holds off while rows keep coming.
    write_reg(REG_CLOCK_TARGET, 32'd0);
    write_reg(REG_CLOCK_MASK, 32'd1);
    write_reg(REG_POD_TARGET, 32'd0);
    write_reg(REG_POD_MASK, 32'd0);
    write_reg(REG_POD_SELECT, 32'd2);
    write_reg(REG_EDGE_MODE, 32'd0);
    write_reg(REG_ROW_LIMIT, 32'd65536);
    write_reg(REG_SAMPLE_PER, 32'd8000);
    send_calm = 1'b1;
    for (int i = 0; i < PRESSURE_ROWS; i++) begin
      queue_row(i % 12 == 0, {15'($urandom), 1'b0}, WORD_W'($urandom),
                WORD_W'($urandom), WORD_W'($urandom), WORD_W'($urandom));
    end
    hold_go = 1'b1;
    wait_quiet();
    send_calm = 1'b0;

    // Random settings, each with a run of random rows; one run has no idling.
    for (int s = 0; s < RANDOM_SETS; s++) begin
      random_search_cfg();
      send_calm = (s == 4);
      recv_calm = (s == 4);
      goal = rows_handled + RANDOM_ROWS;
      while (rows_handled < goal) begin
        @(posedge clk_i);
        if (trace_rows.size() < 2) trace_rows.push_back(make_row());
      end
      wait_quiet();
    end

    if (mismatch_count == 0 && awaited_reports.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- trace_pattern_edge_search_unit.f -----
+incdir+hw/rtl
hw/rtl/tpes_pkg.sv
hw/rtl/tpes_cfg_regs.sv
hw/rtl/tpes_search.sv
hw/rtl/tpes_div1000.sv
hw/rtl/trace_pattern_edge_search_unit.sv
hw/rtl/tpes_checker.sv
dv/tb_top.sv
